>>> design/kpvt_pkg.sv
// kpvt_pkg: shared constants and codes for the position-velocity tracker
// no dependencies; imported by every module of the block

package kpvt_pkg;

    localparam int DEF_VALUE_WIDTH   = 48;
    localparam int DEF_FRACTION_BITS = 16;

    // fixed field widths of the ports
    localparam int POS_W   = 48;
    localparam int STEP_W  = 32;
    localparam int UCFG_W  = 47;
    localparam int SCFG_W  = 48;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 48;

    typedef enum logic [1:0] {
        ACT_UPDATE  = 2'd0,
        ACT_RESET   = 2'd1,
        ACT_PREDICT = 2'd2,
        ACT_INIT    = 2'd3
    } t_action;

    localparam logic [IDX_W-1:0] REG_COV_POS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COV_CROSS = 3'd1;
    localparam logic [IDX_W-1:0] REG_COV_VEL   = 3'd2;
    localparam logic [IDX_W-1:0] REG_NOISE_POS = 3'd3;
    localparam logic [IDX_W-1:0] REG_NOISE_VEL = 3'd4;
    localparam logic [IDX_W-1:0] REG_NOISE_MEAS = 3'd5;

    localparam logic [UCFG_W-1:0]        RST_COV_POS    = 47'd6554;
    localparam logic signed [SCFG_W-1:0] RST_COV_CROSS  = 48'sd6554;
    localparam logic [UCFG_W-1:0]        RST_COV_VEL    = 47'd6554;
    localparam logic [UCFG_W-1:0]        RST_NOISE_POS  = 47'd655;
    localparam logic [UCFG_W-1:0]        RST_NOISE_VEL  = 47'd655;
    localparam logic [UCFG_W-1:0]        RST_NOISE_MEAS = 47'd6553600000;

endpackage

>>> design/kpvt_mul.sv
// kpvt_mul: bit-serial signed fixed-point multiplier, one multiplier bit a cycle
// depends on kpvt_pkg; result saturates to the signed value range

module kpvt_mul
    import kpvt_pkg::*;
#(
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [VALUE_WIDTH-1:0] i_a,
    input  logic signed [VALUE_WIDTH-1:0] i_b,
    output logic                          o_done,
    output logic signed [VALUE_WIDTH-1:0] o_res
);
    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [2*W-1:0] LIM = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} t_mstate;

    t_mstate         r_state;
    logic [W-1:0]    r_ma, r_mb;
    logic [2*W-1:0]  r_acc;
    logic            r_neg;
    logic [CW-1:0]   r_cnt;
    logic            r_done;
    logic signed [W-1:0] r_res;
    logic [W:0]      n_sum;
    logic [2*W-1:0]  n_sh;

    assign n_sum = {1'b0, r_acc[2*W-1:W]} + (r_mb[0] ? {1'b0, r_ma} : {(W+1){1'b0}});
    assign n_sh  = r_acc >> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_ma    <= i_a[W-1] ? W'(-i_a) : W'(i_a);
                        r_mb    <= i_b[W-1] ? W'(-i_b) : W'(i_b);
                        r_neg   <= i_a[W-1] ^ i_b[W-1];
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    r_acc <= {n_sum, r_acc[W-1:1]};
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) begin
                        r_state <= M_FIN;
                    end
                end
                M_FIN: begin
                    if (!r_neg) begin
                        r_res <= (n_sh > LIM) ? VMAX : n_sh[W-1:0];
                    end else begin
                        r_res <= (n_sh > LIM + 1'b1) ? VMIN : -n_sh[W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

>>> design/kpvt_div.sv
// kpvt_div: restoring divider for (a << fraction) / b, one quotient bit a cycle
// depends on kpvt_pkg; non-positive divisor gives zero, result saturates

module kpvt_div
    import kpvt_pkg::*;
#(
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [VALUE_WIDTH-1:0] i_a,
    input  logic signed [VALUE_WIDTH-1:0] i_b,
    output logic                          o_done,
    output logic signed [VALUE_WIDTH-1:0] o_res
);
    localparam int W  = VALUE_WIDTH;
    localparam int NW = VALUE_WIDTH + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] LIM = {{(FRACTION_BITS+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} t_dstate;

    t_dstate        r_state;
    logic [NW-1:0]  r_num, r_q;
    logic [W:0]     r_rem;
    logic [W-1:0]   r_den;
    logic           r_neg, r_zero;
    logic [CW-1:0]  r_cnt;
    logic           r_done;
    logic signed [W-1:0] r_res;
    logic [W:0]     n_rsh;
    logic           n_ge;

    assign n_rsh = {r_rem[W-1:0], r_num[NW-1]};
    assign n_ge  = n_rsh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= {(i_a[W-1] ? W'(-i_a) : W'(i_a)),
                                    {FRACTION_BITS{1'b0}}};
                        r_den   <= W'(i_b);
                        r_neg   <= i_a[W-1];
                        r_zero  <= i_b[W-1] || (i_b == '0);
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= n_ge ? (n_rsh - {1'b0, r_den}) : n_rsh;
                    r_q   <= {r_q[NW-2:0], n_ge};
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NW - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (r_zero) begin
                        r_res <= '0;
                    end else if (!r_neg) begin
                        r_res <= (r_q > LIM) ? VMAX : r_q[W-1:0];
                    end else begin
                        r_res <= (r_q > LIM + 1'b1) ? VMIN : -r_q[W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

>>> design/kalman_position_velocity_tracker.sv
// kalman_position_velocity_tracker: 1-d constant-velocity kalman tracker, top level
// depends on kpvt_pkg, kpvt_mul and kpvt_div
//
//  channel | signals                                   | dir | word
//  --------+-------------------------------------------+-----+--------------------------
//  in      | i_in_valid / o_in_ready                   | in  | action, position, step
//  out     | o_out_valid / i_out_ready                 | out | estimates, prediction, flag
//  cfg     | i_cfg_valid / o_cfg_ready                 | in  | register index, data
//
// an update runs 12 operations on a serial multiplier and a serial divider; the first
// sample after a reset takes one divide, a predict one multiply, and reset/init and
// an ignored step go straight to the finish step
// one word is in flight at a time; o_in_ready is high only while the sequencer is idle
// a finished result waits in the output register; a stalled output holds the sequencer
// synchronous active-low reset; config writes are always taken

module kalman_position_velocity_tracker
    import kpvt_pkg::*;
#(
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_action,
    input  logic signed [POS_W-1:0]  i_position,
    input  logic [STEP_W-1:0]        i_time_step,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [POS_W-1:0]  o_position_estimate,
    output logic signed [POS_W-1:0]  o_velocity_estimate,
    output logic signed [POS_W-1:0]  o_predicted_position,
    output logic                     o_step_ignored,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);
    localparam int W  = VALUE_WIDTH;
    localparam int XW = ((W > POS_W) ? W : POS_W) + 2;

    typedef logic signed [W-1:0]  t_val;
    typedef logic signed [XW-1:0] t_wide;

    localparam t_wide VMAX_X = (t_wide'(1) <<< (W - 1)) - t_wide'(1);
    localparam t_wide VMIN_X = -VMAX_X - t_wide'(1);
    localparam t_val  VMAX   = {1'b0, {(W-1){1'b1}}};
    localparam t_val  VMIN   = {1'b1, {(W-1){1'b0}}};

    // wide value into the signed value range
    function automatic t_val clampx(t_wide x);
        t_val v;
        if (x > VMAX_X) begin
            v = VMAX;
        end else if (x < VMIN_X) begin
            v = VMIN;
        end else begin
            v = x[W-1:0];
        end
        return v;
    endfunction

    function automatic t_val sadd(t_val a, t_val b);
        return clampx(t_wide'(a) + t_wide'(b));
    endfunction

    // negating the most negative value saturates first
    function automatic t_val ssub(t_val a, t_val b);
        t_val nb;
        nb = (b == VMIN) ? VMAX : -b;
        return sadd(a, nb);
    endfunction

    function automatic logic [POS_W-1:0] to_port(t_val v);
        t_wide x;
        x = t_wide'(v);
        return x[POS_W-1:0];
    endfunction

    typedef enum logic [4:0] {
        S_IDLE, S_PRED, S_SEED,
        S_U1, S_U2, S_U3, S_U4, S_U5, S_U6, S_U7, S_U8, S_U9, S_U10, S_U11, S_U12,
        S_FIN
    } t_state;

    // configuration registers, raw field widths
    logic [UCFG_W-1:0] r_cfg_cp, r_cfg_cv, r_cfg_qp, r_cfg_qv, r_cfg_r;
    logic signed [SCFG_W-1:0] r_cfg_cc;

    t_state r_state;
    logic   r_launched;
    t_val   r_pos, r_vel, r_cp, r_cc, r_cv;
    logic   r_vvalid;
    t_val   r_z, r_dt, r_t, r_kx, r_kv, r_pred;
    logic   r_ign;
    logic   r_out_valid;
    logic [POS_W-1:0] r_out_pos, r_out_vel, r_out_pred;
    logic   r_out_ign;

    t_val   qp_v, qv_v, r_v, s_v, one_m, one_v, z_in, dt_in;
    t_val   op_a, op_b, unit_res;
    logic   mul_go, div_go, mul_done, div_done, unit_done, is_div;
    t_val   mul_res, div_res;
    logic   in_acc, out_free;
    t_action act_in;

    // registers are brought into range when used
    assign qp_v  = clampx(t_wide'(r_cfg_qp));
    assign qv_v  = clampx(t_wide'(r_cfg_qv));
    assign r_v   = clampx(t_wide'(r_cfg_r));
    assign s_v   = sadd(r_cp, r_v);
    assign one_v = clampx(t_wide'(1) <<< FRACTION_BITS);
    assign one_m = ssub(one_v, r_kx);
    assign z_in  = clampx(t_wide'(i_position));
    assign dt_in = clampx(t_wide'(i_time_step));
    assign act_in = t_action'(i_action);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // operand select for the shared units
    always_comb begin
        op_a   = r_dt;
        op_b   = r_dt;
        is_div = 1'b0;
        case (r_state)
            S_PRED:  begin op_a = r_vel; op_b = r_dt; end
            S_SEED:  begin op_a = ssub(r_z, r_pos); op_b = r_dt; is_div = 1'b1; end
            S_U1:    begin op_a = r_vel; op_b = r_dt; end
            S_U2:    begin op_a = r_dt; op_b = r_cv; end
            S_U3:    begin op_a = r_dt; op_b = sadd(sadd(r_cc, r_cc), r_t); end
            S_U4:    begin op_a = r_dt; op_b = qp_v; end
            S_U5:    begin op_a = r_dt; op_b = qv_v; end
            S_U6:    begin op_a = r_cp; op_b = s_v; is_div = 1'b1; end
            S_U7:    begin op_a = r_cc; op_b = s_v; is_div = 1'b1; end
            S_U8:    begin op_a = r_t; op_b = r_kx; end
            S_U9:    begin op_a = r_t; op_b = r_kv; end
            S_U10:   begin op_a = r_kv; op_b = r_cc; end
            S_U11:   begin op_a = r_cp; op_b = one_m; end
            S_U12:   begin op_a = r_cc; op_b = one_m; end
            default: begin op_a = r_dt; op_b = r_dt; end
        endcase
    end

    assign mul_go = !r_launched && !is_div && (r_state != S_IDLE) && (r_state != S_FIN);
    assign div_go = !r_launched && is_div;
    assign unit_done = mul_done || div_done;
    assign unit_res  = is_div ? div_res : mul_res;

    kpvt_mul #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_go),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_done (mul_done),
        .o_res  (mul_res)
    );

    kpvt_div #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_go),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_done (div_done),
        .o_res  (div_res)
    );

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cp <= RST_COV_POS;
            r_cfg_cc <= RST_COV_CROSS;
            r_cfg_cv <= RST_COV_VEL;
            r_cfg_qp <= RST_NOISE_POS;
            r_cfg_qv <= RST_NOISE_VEL;
            r_cfg_r  <= RST_NOISE_MEAS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COV_POS:    r_cfg_cp <= i_cfg_data[UCFG_W-1:0];
                REG_COV_CROSS:  r_cfg_cc <= i_cfg_data[SCFG_W-1:0];
                REG_COV_VEL:    r_cfg_cv <= i_cfg_data[UCFG_W-1:0];
                REG_NOISE_POS:  r_cfg_qp <= i_cfg_data[UCFG_W-1:0];
                REG_NOISE_VEL:  r_cfg_qv <= i_cfg_data[UCFG_W-1:0];
                REG_NOISE_MEAS: r_cfg_r  <= i_cfg_data[UCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launched  <= 1'b0;
            r_pos       <= '0;
            r_vel       <= '0;
            r_vvalid    <= 1'b0;
            r_cp        <= clampx(t_wide'(RST_COV_POS));
            r_cc        <= clampx(t_wide'(RST_COV_CROSS));
            r_cv        <= clampx(t_wide'(RST_COV_VEL));
            r_out_valid <= 1'b0;
        end else begin
            // the finish step reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            if (mul_go || div_go) begin
                r_launched <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_z    <= z_in;
                        r_dt   <= dt_in;
                        r_pred <= '0;
                        r_ign  <= 1'b0;
                        r_state <= S_FIN;
                        case (act_in)
                            ACT_UPDATE: begin
                                if (dt_in == '0) begin
                                    r_ign <= 1'b1;
                                end else if (!r_vvalid) begin
                                    r_state <= S_SEED;
                                end else begin
                                    r_state <= S_U1;
                                end
                            end
                            ACT_PREDICT: r_state <= S_PRED;
                            ACT_RESET, ACT_INIT: begin
                                r_pos    <= z_in;
                                r_vel    <= '0;
                                r_vvalid <= 1'b0;
                                if (act_in == ACT_INIT) begin
                                    r_cp <= clampx(t_wide'(r_cfg_cp));
                                    r_cc <= clampx(t_wide'(r_cfg_cc));
                                    r_cv <= clampx(t_wide'(r_cfg_cv));
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= to_port(r_pos);
                        r_out_vel   <= to_port(r_vel);
                        r_out_pred  <= to_port(r_pred);
                        r_out_ign   <= r_ign;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    if (unit_done) begin
                        r_launched <= 1'b0;
                        case (r_state)
                            S_PRED: begin
                                r_pred  <= sadd(r_z, unit_res);
                                r_state <= S_FIN;
                            end
                            S_SEED: begin
                                r_vel    <= unit_res;
                                r_pos    <= r_z;
                                r_vvalid <= 1'b1;
                                r_state  <= S_FIN;
                            end
                            S_U1: begin
                                r_pos   <= sadd(r_pos, unit_res);
                                r_state <= S_U2;
                            end
                            S_U2: begin
                                r_t     <= unit_res;
                                r_state <= S_U3;
                            end
                            S_U3: begin
                                r_cp    <= sadd(r_cp, unit_res);
                                r_cc    <= sadd(r_cc, r_t);
                                r_state <= S_U4;
                            end
                            S_U4: begin
                                r_cp    <= sadd(r_cp, unit_res);
                                r_state <= S_U5;
                            end
                            S_U5: begin
                                r_cv    <= sadd(r_cv, unit_res);
                                r_state <= S_U6;
                            end
                            S_U6: begin
                                r_kx    <= unit_res;
                                r_state <= S_U7;
                            end
                            S_U7: begin
                                // innovation taken once, before any correction
                                r_kv    <= unit_res;
                                r_t     <= ssub(r_z, r_pos);
                                r_state <= S_U8;
                            end
                            S_U8: begin
                                r_pos   <= sadd(r_pos, unit_res);
                                r_state <= S_U9;
                            end
                            S_U9: begin
                                r_vel   <= sadd(r_vel, unit_res);
                                r_state <= S_U10;
                            end
                            S_U10: begin
                                r_cv    <= ssub(r_cv, unit_res);
                                r_state <= S_U11;
                            end
                            S_U11: begin
                                r_cp    <= unit_res;
                                r_state <= S_U12;
                            end
                            S_U12: begin
                                r_cc    <= unit_res;
                                r_state <= S_FIN;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_position_estimate  = r_out_pos;
    assign o_velocity_estimate  = r_out_vel;
    assign o_predicted_position = r_out_pred;
    assign o_step_ignored       = r_out_ign;

    // the two units never finish together
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished in the same cycle");

    // a unit result only arrives while a word is being worked on
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_done |-> !o_in_ready)
        else $error("unit result while sequencer idle");

    // a new result word comes only out of the finish step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("output word without finish step");

    // reset and init clear the velocity-seeded flag
    a_reseed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (act_in == ACT_RESET || act_in == ACT_INIT)) |=> !r_vvalid)
        else $error("velocity flag not cleared on reset or init");

endmodule

>>> dv/tb_kalman_position_velocity_tracker.sv
// testbench for kalman_position_velocity_tracker: directed table then random tracks
// depends on kpvt_pkg and the tracker rtl; self-checking against an in-bench predictor
`timescale 1ns / 100ps

module tb_kalman_position_velocity_tracker;
    import kpvt_pkg::*;

    localparam longint VMAX = (64'sd1 <<< 47) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam longint ONE  = 64'sd1 <<< 16;
    localparam int     NPHASE = 6;
    localparam int     PHASE_WORDS = 230;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] vel;
        logic signed [POS_W-1:0] pred;
        logic                    ign;
    } t_estimate;

    // directed row: typed result only where it is obvious
    typedef struct {
        t_action                 act;
        logic signed [POS_W-1:0] pos;
        logic [STEP_W-1:0]       step;
        bit                      typed;
        t_estimate               res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [1:0] i_action;
    logic signed [POS_W-1:0] i_position;
    logic [STEP_W-1:0] i_time_step;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [POS_W-1:0] o_position_estimate;
    logic signed [POS_W-1:0] o_velocity_estimate;
    logic signed [POS_W-1:0] o_predicted_position;
    logic o_step_ignored;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;

    kalman_position_velocity_tracker dut (.*);

    always #5 i_clk = ~i_clk;

    // tracker state as the predictor sees it
    longint est_pos, est_vel, cv_pos, cv_cross, cv_vel;
    bit     vel_seeded;
    logic [DATA_W-1:0] cfg_reg [6];

    t_estimate estimates_q[$];
    int  n_bad;
    int  burst_left;
    int  gap_max;

    // ---------------------------------------------------------------------------
    // saturating fixed-point arithmetic
    // ---------------------------------------------------------------------------
    function automatic longint clip(input logic signed [127:0] v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return longint'(v);
    endfunction

    function automatic longint sat_add(input longint a, input longint b);
        return clip(128'(signed'(a)) + 128'(signed'(b)));
    endfunction

    // minus of the most negative value is taken as the most positive one
    function automatic longint sat_sub(input longint a, input longint b);
        return sat_add(a, (b == VMIN) ? VMAX : -b);
    endfunction

    // signed result from a magnitude, saturating
    function automatic longint signed_of(input bit neg, input logic [127:0] m);
        if (!neg) return (m > 128'(VMAX)) ? VMAX : longint'(m);
        if (m > 128'(VMAX) + 1) return VMIN;
        return -longint'(m);
    endfunction

    function automatic logic [127:0] magnitude(input longint a);
        return (a < 0) ? 128'(-128'(signed'(a))) : 128'(a);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return signed_of((a < 0) != (b < 0), (magnitude(a) * magnitude(b)) >> 16);
    endfunction

    // non-positive denominator gives zero
    function automatic longint qdiv(input longint a, input longint b);
        if (b <= 0) return 0;
        return signed_of(a < 0, (magnitude(a) << 16) / 128'(b));
    endfunction

    function automatic longint ureg(input int k);
        return longint'(cfg_reg[k][UCFG_W-1:0]);
    endfunction

    function automatic void reload_cov();
        cv_pos   = ureg(REG_COV_POS);
        cv_cross = longint'(signed'(cfg_reg[REG_COV_CROSS]));
        cv_vel   = ureg(REG_COV_VEL);
    endfunction

    // one filter step; returns the estimate word the block must produce
    function automatic t_estimate track_step(input t_action act,
                                             input logic signed [POS_W-1:0] z_in,
                                             input logic [STEP_W-1:0] step);
        longint z, dt, pred, t, s, kx, kv, e, one_m;
        t_estimate r;
        z = longint'(z_in);
        dt = longint'(step);
        pred = 0;
        r.ign = 1'b0;
        case (act)
            ACT_UPDATE: begin
                if (dt == 0) begin
                    r.ign = 1'b1;
                end else if (!vel_seeded) begin
                    est_vel = qdiv(sat_sub(z, est_pos), dt);
                    est_pos = z;
                    vel_seeded = 1'b1;
                end else begin
                    est_pos  = sat_add(est_pos, qmul(est_vel, dt));
                    t        = qmul(dt, cv_vel);
                    cv_pos   = sat_add(cv_pos, qmul(dt, sat_add(sat_add(cv_cross, cv_cross), t)));
                    cv_cross = sat_add(cv_cross, t);
                    cv_pos   = sat_add(cv_pos, qmul(dt, ureg(REG_NOISE_POS)));
                    cv_vel   = sat_add(cv_vel, qmul(dt, ureg(REG_NOISE_VEL)));
                    s        = sat_add(cv_pos, ureg(REG_NOISE_MEAS));
                    kx       = qdiv(cv_pos, s);
                    kv       = qdiv(cv_cross, s);
                    // innovation taken once, ahead of the correction
                    e        = sat_sub(z, est_pos);
                    est_pos  = sat_add(est_pos, qmul(e, kx));
                    est_vel  = sat_add(est_vel, qmul(e, kv));
                    // velocity variance uses the cross term before it shrinks
                    cv_vel   = sat_sub(cv_vel, qmul(kv, cv_cross));
                    one_m    = sat_sub(ONE, kx);
                    cv_pos   = qmul(cv_pos, one_m);
                    cv_cross = qmul(cv_cross, one_m);
                end
            end
            ACT_PREDICT: pred = sat_add(z, qmul(est_vel, dt));
            default: begin
                est_pos = z;
                est_vel = 0;
                vel_seeded = 1'b0;
                if (act == ACT_INIT) reload_cov();
            end
        endcase
        r.pos  = est_pos[POS_W-1:0];
        r.vel  = est_vel[POS_W-1:0];
        r.pred = pred[POS_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------------
    // result checker: every accepted word against the oldest expectation
    // ---------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_estimate got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_position_estimate, o_velocity_estimate, o_predicted_position,
                    o_step_ignored};
            if (estimates_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected word: pos %0d vel %0d pred %0d ign %0b",
                             got.pos, got.vel, got.pred, got.ign);
            end else begin
                want = estimates_q.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: exp %0d %0d %0d %0b / got %0d %0d %0d %0b",
                                 want.pos, want.vel, want.pred, want.ign,
                                 got.pos, got.vel, got.pred, got.ign);
                end
            end
        end
    end

    // receiver stalls: mode changes every stretch; always-ready, coin flip, mostly stalled
    int rx_mode, rx_left;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(50, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= $urandom_range(0, 1);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ---------------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------------
    // holds the word until taken; valid stays high if the next word follows at once
    task automatic send_word(input t_action act, input logic signed [POS_W-1:0] z,
                             input logic [STEP_W-1:0] step, input bit typed,
                             input t_estimate res);
        t_estimate p;
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_position  <= z;
        i_time_step <= step;
        do @(posedge i_clk); while (!o_in_ready);
        p = track_step(act, z, step);
        estimates_q.push_back(typed ? res : p);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
    endtask

    // all results back and the block at rest before registers move
    task automatic drain();
        i_in_valid <= 1'b0;
        while (estimates_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_reg[idx] = (idx == REG_COV_CROSS) ? d : {1'b0, d[UCFG_W-1:0]};
    endtask

    task automatic write_all(input logic [DATA_W-1:0] d [6]);
        for (int k = 0; k < 6; k++) write_reg(IDX_W'(k), d[k]);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand48();
        return DATA_W'({$urandom(), $urandom()});
    endfunction

    // ---------------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------------
    t_row dir_rows[$];

    function automatic t_estimate typed_res(input longint p, input longint v,
                                            input longint pr, input bit ig);
        t_estimate r;
        r.pos = p[POS_W-1:0];
        r.vel = v[POS_W-1:0];
        r.pred = pr[POS_W-1:0];
        r.ign = ig;
        return r;
    endfunction

    function automatic void add_row(input t_action a, input longint z, input longint dt,
                                    input bit typed, input t_estimate r);
        t_row row;
        row.act = a;
        row.pos = z[POS_W-1:0];
        row.step = dt[STEP_W-1:0];
        row.typed = typed;
        row.res = r;
        dir_rows.push_back(row);
    endfunction

    initial begin
        longint trk_pos, trk_vel, z, dt;
        logic [DATA_W-1:0] setting [6];
        int n;
        t_action a;
        t_estimate none;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_UPDATE;
        i_position  <= '0;
        i_time_step <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_out_ready <= 1'b1;
        rx_mode = 0;
        rx_left = 0;
        n_bad = 0;
        burst_left = 0;
        gap_max = 6;
        none = '0;

        // predictor comes out of reset like the block
        est_pos = 0;
        est_vel = 0;
        vel_seeded = 1'b0;
        cfg_reg[REG_COV_POS]    = DATA_W'(RST_COV_POS);
        cfg_reg[REG_COV_CROSS]  = DATA_W'(RST_COV_CROSS);
        cfg_reg[REG_COV_VEL]    = DATA_W'(RST_COV_VEL);
        cfg_reg[REG_NOISE_POS]  = DATA_W'(RST_NOISE_POS);
        cfg_reg[REG_NOISE_VEL]  = DATA_W'(RST_NOISE_VEL);
        cfg_reg[REG_NOISE_MEAS] = DATA_W'(RST_NOISE_MEAS);
        reload_cov();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: extremes, every action, ignored step, seeding, saturation
        add_row(ACT_PREDICT, 0, 0, 1, typed_res(0, 0, 0, 0));
        add_row(ACT_RESET, VMAX, 7, 1, typed_res(VMAX, 0, 0, 0));
        add_row(ACT_RESET, VMIN, 0, 1, typed_res(VMIN, 0, 0, 0));
        add_row(ACT_UPDATE, 123, 0, 1, typed_res(VMIN, 0, 0, 1));
        // first sample seeds a saturated velocity
        add_row(ACT_UPDATE, VMAX, 1, 1, typed_res(VMAX, VMAX, 0, 0));
        add_row(ACT_PREDICT, VMAX, 32'hFFFF_FFFF, 1, typed_res(VMAX, VMAX, VMAX, 0));
        add_row(ACT_PREDICT, VMIN, 32'hFFFF_FFFF, 1, typed_res(VMAX, VMAX, -1, 0));
        add_row(ACT_UPDATE, VMIN, 32'hFFFF_FFFF, 0, none);
        add_row(ACT_UPDATE, 0, 1, 0, none);
        add_row(ACT_INIT, 0, 32'hFFFF_FFFF, 1, typed_res(0, 0, 0, 0));
        add_row(ACT_UPDATE, 1000 * ONE, ONE, 0, none);
        add_row(ACT_UPDATE, 1010 * ONE, ONE, 0, none);
        add_row(ACT_UPDATE, 1021 * ONE, ONE, 0, none);
        add_row(ACT_UPDATE, 1029 * ONE, ONE / 2, 0, none);
        add_row(ACT_UPDATE, 1029 * ONE, 0, 0, none);
        add_row(ACT_PREDICT, -5 * ONE, 3 * ONE, 0, none);
        add_row(ACT_UPDATE, -40 * ONE, 10 * ONE, 0, none);
        add_row(ACT_RESET, -7 * ONE, ONE, 1, typed_res(-7 * ONE, 0, 0, 0));
        add_row(ACT_UPDATE, 0, 1, 0, none);
        add_row(ACT_UPDATE, VMAX, 32'h8000_0000, 0, none);
        add_row(ACT_PREDICT, 0, 32'h8000_0000, 0, none);
        foreach (dir_rows[i])
            send_word(dir_rows[i].act, dir_rows[i].pos, dir_rows[i].step,
                      dir_rows[i].typed, dir_rows[i].res);
        drain();

        // random phases, each under its own register setting, started by an init
        for (int ph = 0; ph < NPHASE; ph++) begin
            case (ph)
                0: setting = '{48'd6554, 48'd6554, 48'd6554, 48'd655, 48'd655, 48'd6553600000};
                // all zero: no variance, no noise, gain denominator zero
                1: setting = '{default: 48'd0};
                2: setting = '{default: 48'hFFFF_FFFF_FFFF};
                3: setting = '{48'd65536, 48'h8000_0000_0000, 48'd65536, 48'd1, 48'd1, 48'd1};
                4: for (int k = 0; k < 6; k++)
                       setting[k] = 48'($urandom_range(1, 32'h00FF_FFFF)) << $urandom_range(0, 8);
                default: for (int k = 0; k < 6; k++) setting[k] = rand48();
            endcase
            write_all(setting);
            gap_max = (ph == 2) ? 0 : $urandom_range(2, 20);
            trk_pos = $signed($urandom_range(0, 32'h7FFF)) * ONE;
            trk_vel = $signed($urandom_range(0, 200)) * 1000 - 100000;
            send_word(ACT_INIT, trk_pos[POS_W-1:0], $urandom(), 0, none);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                n = $urandom_range(0, 99);
                if (n < 70) begin
                    // well-formed track: object moving at constant speed plus jitter
                    dt = $urandom_range(32'h1000, 32'h0004_0000);
                    trk_pos = sat_add(trk_pos, qmul(trk_vel, dt));
                    z = sat_add(trk_pos, $signed($urandom_range(0, 65536 * 8)) - 65536 * 4);
                    send_word(ACT_UPDATE, z[POS_W-1:0], dt[STEP_W-1:0], 0, none);
                end else if (n < 78) begin
                    send_word(ACT_PREDICT, trk_pos[POS_W-1:0],
                              $urandom_range(0, 32'h0010_0000), 0, none);
                end else if (n < 82) begin
                    send_word(ACT_UPDATE, trk_pos[POS_W-1:0], 0, 0, none);
                end else if (n < 86) begin
                    a = (n < 84) ? ACT_RESET : ACT_INIT;
                    send_word(a, trk_pos[POS_W-1:0], $urandom(), 0, none);
                end else begin
                    // noise: any action, any position, any step
                    a = t_action'($urandom_range(0, 3));
                    dt = ($urandom_range(0, 3) == 0) ? 0 : $urandom();
                    send_word(a, rand48(), dt[STEP_W-1:0], 0, none);
                end
            end
            drain();
        end

        if (n_bad == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit: a run that has not finished by the time limit fails
    initial begin
        #60ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
